/* sv/mka_pkg.sv */
// Package for the menu key autorepeat unit.
// Holds payload structs, button bit masks, menu action codes, phase codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package mka_pkg;

	typedef struct packed {
		logic [17:0] button_bits;
		logic [7:0]  stick_x;
		logic [7:0]  stick_y;
		logic [31:0] sample_time;
	} mka_in_t;

	typedef struct packed {
		logic [3:0]  menu_action;
		logic [15:0] held_buttons;
	} mka_out_t;

	localparam logic [15:0] BTN_SELECT = 16'h0001;
	localparam logic [15:0] BTN_START  = 16'h0008;
	localparam logic [15:0] BTN_UP     = 16'h0010;
	localparam logic [15:0] BTN_RIGHT  = 16'h0020;
	localparam logic [15:0] BTN_DOWN   = 16'h0040;
	localparam logic [15:0] BTN_LEFT   = 16'h0080;
	localparam logic [15:0] BTN_LTRIG  = 16'h0100;
	localparam logic [15:0] BTN_RTRIG  = 16'h0200;
	localparam logic [15:0] BTN_CIRCLE = 16'h2000;
	localparam logic [15:0] BTN_CROSS  = 16'h4000;
	localparam logic [15:0] BTN_SQUARE = 16'h8000;
	localparam logic [15:0] BTN_REPEATABLE =
		BTN_UP | BTN_RIGHT | BTN_DOWN | BTN_LEFT | BTN_LTRIG | BTN_RTRIG;
	localparam int unsigned HOLD_SWITCH_BIT = 17;

	localparam logic [3:0] ACT_NONE    = 4'd0;
	localparam logic [3:0] ACT_RTRIG   = 4'd1;
	localparam logic [3:0] ACT_LTRIG   = 4'd2;
	localparam logic [3:0] ACT_LEFT    = 4'd3;
	localparam logic [3:0] ACT_RIGHT   = 4'd4;
	localparam logic [3:0] ACT_UP      = 4'd5;
	localparam logic [3:0] ACT_DOWN    = 4'd6;
	localparam logic [3:0] ACT_SELECT  = 4'd7;
	localparam logic [3:0] ACT_DEFAULT = 4'd8;
	localparam logic [3:0] ACT_EXIT    = 4'd9;
	localparam logic [3:0] ACT_BACK    = 4'd10;

	localparam logic [1:0] PHASE_NOT_HELD = 2'd0;
	localparam logic [1:0] PHASE_INITIAL  = 2'd1;
	localparam logic [1:0] PHASE_REPEAT   = 2'd2;

	localparam logic [1:0] REG_ANALOG_ENABLE = 2'd0;
	localparam logic [1:0] REG_ANALOG_THRESH = 2'd1;
	localparam logic [1:0] REG_START_DELAY   = 2'd2;
	localparam logic [1:0] REG_INTERVAL      = 2'd3;

	localparam logic [7:0]  THRESH_RESET = 8'd20;
	localparam logic [31:0] DELAY_RESET  = 32'd200000;
	localparam logic [31:0] INTVL_RESET  = 32'd50000;
	localparam logic [7:0]  STICK_MAX    = 8'd255;

endpackage

`default_nettype wire

/* sv/menu_key_autorepeat_unit.sv */
// Menu key autorepeat unit: an input transfer loads the input register, and the result
// register is loaded from it when not stalled. Throughput one sample per cycle;
// the input register feeds one pass of compare, priority select and 32-bit wrapped
// time compare into the result register, and a stalled result holds both registers.
// Reset (arst_n low) clears button history, repeat state, valid flags and loads
// register defaults: analog off, threshold 20, delay 200000 us, interval 50000 us.
// Depends on mka_pkg.
`default_nettype none

module menu_key_autorepeat_unit
	import mka_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire mka_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output mka_out_t         out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic        analog_enable_q;
	logic [7:0]  analog_threshold_q;
	logic [31:0] start_delay_q;
	logic [31:0] interval_q;

	logic        valid_s1;
	mka_in_t     item_s1;
	logic        out_valid_q;
	mka_out_t    out_data_q;

	logic [15:0] prev_buttons_q;
	logic [1:0]  phase_q;
	logic [15:0] rep_buttons_q;
	logic [3:0]  rep_action_q;
	logic [31:0] rep_time_q;

	logic        advance;
	logic        cfg_write;
	logic [1:0]  reg_index;
	logic [7:0]  inv_thresh;
	logic [15:0] buttons;
	logic [15:0] fresh;
	logic [3:0]  new_action;
	logic [3:0]  action;
	logic [31:0] elapsed;
	logic        fire;

	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		unique case (reg_index)
			REG_ANALOG_ENABLE: prdata = {31'd0, analog_enable_q};
			REG_ANALOG_THRESH: prdata = {24'd0, analog_threshold_q};
			REG_START_DELAY:   prdata = start_delay_q;
			REG_INTERVAL:      prdata = interval_q;
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			analog_enable_q    <= 1'b0;
			analog_threshold_q <= THRESH_RESET;
			start_delay_q      <= DELAY_RESET;
			interval_q         <= INTVL_RESET;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_ANALOG_ENABLE: analog_enable_q    <= pwdata[0];
				REG_ANALOG_THRESH: analog_threshold_q <= pwdata[7:0];
				REG_START_DELAY:   start_delay_q      <= pwdata;
				REG_INTERVAL:      interval_q         <= pwdata;
				default:           ;
			endcase
		end
	end

	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		inv_thresh = STICK_MAX - analog_threshold_q;
		buttons    = item_s1.button_bits[15:0];
		if (analog_enable_q && !item_s1.button_bits[HOLD_SWITCH_BIT]) begin
			if (item_s1.stick_x < analog_threshold_q) buttons = buttons | BTN_LEFT;
			if (item_s1.stick_x > inv_thresh)         buttons = buttons | BTN_RIGHT;
			if (item_s1.stick_y < analog_threshold_q) buttons = buttons | BTN_UP;
			if (item_s1.stick_y > inv_thresh)         buttons = buttons | BTN_DOWN;
		end
		fresh = (prev_buttons_q ^ buttons) & buttons;

		new_action = ACT_NONE;
		if ((fresh & BTN_RTRIG)  != '0) new_action = ACT_RTRIG;
		if ((fresh & BTN_LTRIG)  != '0) new_action = ACT_LTRIG;
		if ((fresh & BTN_LEFT)   != '0) new_action = ACT_LEFT;
		if ((fresh & BTN_RIGHT)  != '0) new_action = ACT_RIGHT;
		if ((fresh & BTN_UP)     != '0) new_action = ACT_UP;
		if ((fresh & BTN_DOWN)   != '0) new_action = ACT_DOWN;
		if ((fresh & BTN_START)  != '0) new_action = ACT_SELECT;
		if ((fresh & BTN_SELECT) != '0) new_action = ACT_DEFAULT;
		if ((fresh & BTN_CIRCLE) != '0) new_action = ACT_SELECT;
		if ((fresh & BTN_CROSS)  != '0) new_action = ACT_EXIT;
		if ((fresh & BTN_SQUARE) != '0) new_action = ACT_BACK;

		elapsed = item_s1.sample_time - rep_time_q;
		fire    = 1'b0;
		if ((buttons & rep_buttons_q) != '0) begin
			if (phase_q == PHASE_INITIAL) fire = elapsed > start_delay_q;
			else if (phase_q == PHASE_REPEAT) fire = elapsed > interval_q;
		end

		if (new_action != ACT_NONE) action = new_action;
		else if (fire) action = rep_action_q;
		else action = ACT_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			prev_buttons_q <= '0;
			phase_q        <= PHASE_NOT_HELD;
			rep_buttons_q  <= '0;
			rep_action_q   <= ACT_NONE;
			rep_time_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q    <= 1'b1;
				prev_buttons_q <= buttons;
				if (new_action != ACT_NONE) begin
					rep_time_q    <= item_s1.sample_time;
					phase_q       <= PHASE_INITIAL;
					rep_buttons_q <= fresh & BTN_REPEATABLE;
					rep_action_q  <= new_action;
				end else if (fire) begin
					rep_time_q <= item_s1.sample_time;
					phase_q    <= PHASE_REPEAT;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_data_q.menu_action  <= action;
			out_data_q.held_buttons <= buttons;
		end
	end

endmodule

`default_nettype wire
